/* design/pwa_pkg.sv */
// Shared types and constants of the peak width block.
// Used by every module in the design folder; depends on nothing.
package pwa_pkg;

  // one input transfer
  typedef struct packed {
    logic [23:0] two_theta;
    logic [31:0] sum_in;
  } cmd_t;

  // one result transfer
  typedef struct packed {
    logic [31:0] width;
    logic [31:0] sum_out;
    logic        invalid;
  } res_t;

  // derived coefficients handed from the sequencer to the datapath
  typedef struct packed {
    logic [61:0] a_mag;
    logic        a_neg;
    logic [61:0] b;
    logic [49:0] c;
    logic        dist_zero;
  } coef_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DISTANCE  = 3'd0,
    REG_PIXEL     = 3'd1,
    REG_LAYER     = 3'd2,
    REG_SAMPLE    = 3'd3,
    REG_DIVERGE   = 3'd4
  } reg_idx_t;

  localparam logic [23:0] RST_DISTANCE = 24'd13107200;
  localparam logic [23:0] RST_PIXEL    = 24'd6554;
  localparam logic [23:0] RST_LAYER    = 24'd32768;
  localparam logic [23:0] RST_SAMPLE   = 24'd65536;
  localparam logic [23:0] RST_DIVERGE  = 24'd6554;

  localparam logic [32:0] TWO_LN2_Q32     = 33'd5954088944;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] RAD_DEG_Q24     = 32'd961263669;
  localparam logic [61:0] COEF_CAP        = {62{1'b1}};

  localparam logic [31:0] ATAN_DEG_Q24 [16] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335
  };

  // atan(2^-i) in degrees Q.24; small angles use the 180/pi slope
  function automatic logic [31:0] atan_step(input int i);
    logic [32:0] rnd;
    rnd = '0;
    if (i < 16) begin
      atan_step = ATAN_DEG_Q24[i[3:0]];
    end else begin
      rnd = {1'b0, RAD_DEG_Q24} + (33'd1 << (i - 1));
      atan_step = 32'(rnd >> i);
    end
  endfunction

endpackage

/* design/pwa_coef.sv */
// Configuration registers and the sequencer that derives coefficients A, B, C.
// Depends on pwa_pkg.
module pwa_coef (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output pwa_pkg::coef_t     coef,
  output logic               busy
);

  typedef enum logic [1:0] {ST_IDLE, ST_SQR, ST_MUL, ST_DIV} state_t;
  typedef enum logic [1:0] {JOB_C, JOB_A, JOB_B} job_t;

  localparam int NUM_W = 84;
  localparam logic [32:0] TWO_LN2 = pwa_pkg::TWO_LN2_Q32;

  state_t            state;
  job_t              job;
  logic [2:0]        cnt;
  logic              half;
  logic [6:0]        dcnt;
  logic [23:0]       dist_mm, pix, lay, samp, divg;
  logic [47:0]       dd, pp, tt, ss, ff;
  logic [NUM_W-1:0]  acc, num, quo;
  logic [47:0]       rem;

  logic [23:0]       sq_op;
  logic [47:0]       sq;
  logic [49:0]       sub, mag, bsrc, src;
  logic              a_neg_n;
  logic [24:0]       part;
  logic [57:0]       prod;
  logic [NUM_W-1:0]  acc_add, acc_sum, q_fin;
  logic [48:0]       rem_sh;
  logic              ge;
  logic [47:0]       rem_next;
  logic [61:0]       q_sat;

  // shared squarer over the five lengths
  always_comb begin
    unique case (cnt)
      3'd0:    sq_op = dist_mm;
      3'd1:    sq_op = pix;
      3'd2:    sq_op = lay;
      3'd3:    sq_op = samp;
      default: sq_op = divg;
    endcase
    sq = sq_op * sq_op;
  end

  // numerators and the shared 33 x 25 multiplier
  always_comb begin
    sub     = (50'(tt) << 1) + 50'(ss);
    a_neg_n = 50'(pp) < sub;
    mag     = a_neg_n ? sub - 50'(pp) : 50'(pp) - sub;
    bsrc    = (50'(tt) + 50'(ss)) << 1;
    unique case (job)
      JOB_C:   src = 50'(ff);
      JOB_A:   src = mag;
      default: src = bsrc;
    endcase
    part    = half ? src[49:25] : src[24:0];
    prod    = 58'(TWO_LN2) * 58'(part);
    acc_add = half ? NUM_W'({prod, 25'd0}) : NUM_W'(prod);
    acc_sum = acc + acc_add;
  end

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh   = {rem, num[NUM_W-1]};
    ge       = rem_sh >= {1'b0, dd};
    rem_next = ge ? 48'(rem_sh - {1'b0, dd}) : rem_sh[47:0];
    q_fin    = {quo[NUM_W-2:0], ge};
    q_sat    = (|q_fin[NUM_W-1:62]) ? pwa_pkg::COEF_CAP : q_fin[61:0];
  end

  // register file and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_mm <= pwa_pkg::RST_DISTANCE;
      pix     <= pwa_pkg::RST_PIXEL;
      lay     <= pwa_pkg::RST_LAYER;
      samp    <= pwa_pkg::RST_SAMPLE;
      divg    <= pwa_pkg::RST_DIVERGE;
      state   <= ST_SQR;
      cnt     <= '0;
      job     <= JOB_C;
      half    <= 1'b0;
    end else if (cfg_we && cfg_index <= 3'(pwa_pkg::REG_DIVERGE)) begin
      unique case (pwa_pkg::reg_idx_t'(cfg_index))
        pwa_pkg::REG_DISTANCE: dist_mm <= cfg_data;
        pwa_pkg::REG_PIXEL:    pix     <= cfg_data;
        pwa_pkg::REG_LAYER:    lay     <= cfg_data;
        pwa_pkg::REG_SAMPLE:   samp    <= cfg_data;
        default:               divg    <= cfg_data;
      endcase
      state <= ST_SQR;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: ;
        ST_SQR: begin
          unique case (cnt)
            3'd0:    dd <= sq;
            3'd1:    pp <= sq;
            3'd2:    tt <= sq;
            3'd3:    ss <= sq;
            default: ff <= sq;
          endcase
          if (cnt == 3'd4) begin
            state <= ST_MUL;
            job   <= JOB_C;
            half  <= 1'b0;
            acc   <= '0;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_MUL: begin
          acc  <= acc_sum;
          half <= 1'b1;
          if (half) begin
            unique case (job)
              JOB_C: begin
                coef.c <= acc_sum[81:32];
                half   <= 1'b0;
                acc    <= '0;
                if (dd == '0) begin
                  coef.dist_zero <= 1'b1;
                  coef.a_mag     <= '0;
                  coef.a_neg     <= 1'b0;
                  coef.b         <= '0;
                  state          <= ST_IDLE;
                end else begin
                  coef.dist_zero <= 1'b0;
                  job            <= JOB_A;
                end
              end
              default: begin
                num   <= acc_sum;
                quo   <= '0;
                rem   <= '0;
                dcnt  <= '0;
                state <= ST_DIV;
              end
            endcase
          end
        end
        default: begin
          num  <= num << 1;
          quo  <= q_fin;
          rem  <= rem_next;
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'(NUM_W - 1)) begin
            if (job == JOB_A) begin
              coef.a_mag <= q_sat;
              coef.a_neg <= a_neg_n;
              job        <= JOB_B;
              half       <= 1'b0;
              acc        <= '0;
              state      <= ST_MUL;
            end else begin
              coef.b <= q_sat;
              state  <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

/* design/pwa_cordic.sv */
// Angle folding and the unrolled rotation-mode CORDIC, one rotation a stage.
// Depends on pwa_pkg.
module pwa_cordic #(
  parameter int STAGES = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [23:0]        angle,
  input  logic [31:0]        sum_in,
  output logic               out_valid,
  output logic signed [33:0] cos_q30,
  output logic [31:0]        sum_out
);

  localparam logic [23:0] DEG180 = 24'd11796480;
  localparam logic [23:0] DEG90  = 24'd5898240;

  logic [23:0]        a1, a2;
  logic               vld [STAGES+1];
  logic signed [33:0] xs  [STAGES+1];
  logic signed [33:0] ys  [STAGES+1];
  logic signed [33:0] zs  [STAGES+1];
  logic [31:0]        ss  [STAGES+1];

  // fold the angle into 0..90 degrees, only even cosine powers are used
  always_comb begin
    a1 = (angle >= DEG180) ? angle - DEG180 : angle;
    a2 = (a1 > DEG90) ? DEG180 - a1 : a1;
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= STAGES; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < STAGES; i++) vld[i+1] <= vld[i];
    end
  end

  // rotation stages
  always_ff @(posedge clk) begin
    xs[0] <= $signed({2'b00, pwa_pkg::CORDIC_GAIN_Q30});
    ys[0] <= '0;
    zs[0] <= $signed({2'b00, a2, 8'h00});
    ss[0] <= sum_in;
    for (int i = 0; i < STAGES; i++) begin
      if (!zs[i][33]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - $signed({2'b00, pwa_pkg::atan_step(i)});
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + $signed({2'b00, pwa_pkg::atan_step(i)});
      end
      ss[i+1] <= ss[i];
    end
  end

  assign out_valid = vld[STAGES];
  assign cos_q30   = xs[STAGES];
  assign sum_out   = ss[STAGES];

endmodule

/* design/pwa_poly.sv */
// Cosine powers, coefficient products and the radicand, eight register stages.
// Depends on pwa_pkg.
module pwa_poly #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [33:0] cos_q30,
  input  logic [31:0]        sum_in,
  input  pwa_pkg::coef_t     coef,
  output logic               out_valid,
  output logic [63:0]        radicand,
  output logic               sat,
  output logic               invalid,
  output logic [31:0]        sum_out
);

  localparam int CW = FRAC_BITS + 1;
  localparam int PW = 2 * CW;
  localparam int MW = 31 + CW;
  localparam int RW = 88;
  localparam int NST = 8;

  logic        vld [NST];
  logic [31:0] ss  [NST];

  logic [30:0]   cq;
  logic [61:0]   sq;
  logic [CW-1:0] c2_3, c2_4, c2_5, c4_5;
  logic [PW-1:0] c4p;
  logic [MW-1:0] bl, bh, al, ah;
  logic [RW-1:0] pos, am;

  logic [30:0]   c2a;
  logic [CW-1:0] c2n, c4n;
  logic [RW-1:0] rad, rs;
  logic          lt;

  // rounding of the two cosine powers
  always_comb begin
    c2a = 31'((sq + (62'd1 << 29)) >> 30);
    c2n = CW'((32'(c2a) + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    c4n = CW'((c4p + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
  end

  // signed combination of the terms
  always_comb begin
    lt  = pos < am;
    rad = coef.a_neg ? pos - am : pos + am;
    rs  = rad >> FRAC_BITS;
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    ss[0] <= sum_in;
    for (int i = 1; i < NST; i++) ss[i] <= ss[i-1];
    // clamp cosine to 0..1
    if (cos_q30[33])                         cq <= '0;
    else if (cos_q30 > 34'sd1073741824)      cq <= 31'h4000_0000;
    else                                     cq <= cos_q30[30:0];
    sq   <= 62'(cq) * 62'(cq);
    c2_3 <= c2n;
    c4p  <= PW'(c2_3) * PW'(c2_3);
    c2_4 <= c2_3;
    c4_5 <= c4n;
    c2_5 <= c2_4;
    // partial products of the 62-bit coefficients
    bl <= MW'(coef.b[30:0])      * MW'(c2_5);
    bh <= MW'(coef.b[61:31])     * MW'(c2_5);
    al <= MW'(coef.a_mag[30:0])  * MW'(c4_5);
    ah <= MW'(coef.a_mag[61:31]) * MW'(c4_5);
    pos <= (RW'(bh) << 31) + RW'(bl) + (RW'(coef.c) << FRAC_BITS);
    am  <= (RW'(ah) << 31) + RW'(al);
    radicand <= rs[63:0];
    sat      <= |rs[RW-1:64];
    invalid  <= coef.dist_zero | (coef.a_neg & lt);
  end

  assign out_valid = vld[NST-1];
  assign sum_out   = ss[NST-1];

endmodule

/* design/pwa_root.sv */
// Pipelined integer square root, one result bit a stage, and the output register.
// Depends on pwa_pkg.
module pwa_root (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [63:0]    radicand,
  input  logic           sat,
  input  logic           invalid,
  input  logic [31:0]    sum_in,
  output logic           done,
  output pwa_pkg::res_t  res
);

  localparam int NST = 32;

  logic        vld [1:NST];
  logic [63:0] rv  [1:NST];
  logic [63:0] rr  [1:NST];
  logic        st  [1:NST];
  logic        iv  [1:NST];
  logic [31:0] ss  [1:NST];

  logic [31:0] wid;
  logic [32:0] sum_w;

  // one root digit: remainder in the upper half, partial root in the lower
  function automatic logic [127:0] root_step(input logic [63:0] v, input logic [63:0] r,
                                             input int j);
    logic [63:0] bt;
    bt = 64'd1 << (62 - 2 * j);
    if (v >= r + bt) root_step = {v - (r + bt), (r >> 1) + bt};
    else             root_step = {v, r >> 1};
  endfunction

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= NST; j++) vld[j] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[1] <= in_valid;
      for (int j = 1; j < NST; j++) vld[j+1] <= vld[j];
      done <= vld[NST];
    end
  end

  // digit-by-digit root steps
  always_ff @(posedge clk) begin
    {rv[1], rr[1]} <= root_step(radicand, 64'd0, 0);
    st[1] <= sat;
    iv[1] <= invalid;
    ss[1] <= sum_in;
    for (int j = 1; j < NST; j++) begin
      {rv[j+1], rr[j+1]} <= root_step(rv[j], rr[j], j);
      st[j+1] <= st[j];
      iv[j+1] <= iv[j];
      ss[j+1] <= ss[j];
    end
  end

  // final width and saturating sum
  always_comb begin
    if (iv[NST])      wid = '0;
    else if (st[NST]) wid = '1;
    else              wid = rr[NST][31:0];
    sum_w = {1'b0, ss[NST]} + {1'b0, wid};
  end

  always_ff @(posedge clk) begin
    res.width   <= wid;
    res.sum_out <= sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
    res.invalid <= iv[NST];
  end

endmodule

/* design/peak_width_vs_angle_model.sv */
// Peak width against diffraction angle: one angle a cycle in while busy is low, one
// width a cycle out; the pipeline never stalls, since results cannot be held off.
// busy is high while the coefficient sequencer runs after reset or a register
// write: five squarings, six multiply steps and two 84-bit restoring divisions
// (only the squarings and the two C multiply steps when distance is zero);
// start is ignored while busy is high.
module peak_width_vs_angle_model #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pwa_pkg::cmd_t  cmd,
  output logic           done,
  output pwa_pkg::res_t  res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data
);

  pwa_pkg::coef_t     coef;
  logic               take;
  logic               cv, pv;
  logic signed [33:0] cos_q30;
  logic [31:0]        csum, psum;
  logic [63:0]        radicand;
  logic               sat, invalid;

  // input transfer
  assign take = start & ~busy;

  pwa_coef u_coef (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .coef(coef), .busy(busy)
  );

  pwa_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst(rst), .in_valid(take), .angle(cmd.two_theta),
    .sum_in(cmd.sum_in), .out_valid(cv), .cos_q30(cos_q30), .sum_out(csum)
  );

  pwa_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk(clk), .rst(rst), .in_valid(cv), .cos_q30(cos_q30), .sum_in(csum),
    .coef(coef), .out_valid(pv), .radicand(radicand), .sat(sat),
    .invalid(invalid), .sum_out(psum)
  );

  pwa_root u_root (
    .clk(clk), .rst(rst), .in_valid(pv), .radicand(radicand), .sat(sat),
    .invalid(invalid), .sum_in(psum), .done(done), .res(res)
  );

endmodule
